[sv/lbr_pkg.sv]
// shared types and constants for the bounded lcg random unit
// no dependencies; used by every module of the block by scoped names
package lbr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = 7;

  // lcg recurrence constants, minimum bound and draw limit
  localparam logic [20:0]       LcgMul    = 21'd1664525;
  localparam logic [DataW-1:0]  LcgAdd    = 32'd1013904223;
  localparam logic [DataW-1:0]  MinBound  = 32'd2;
  localparam logic [CntW-1:0]   DrawLimit = 7'd64;

  // request to the shared remainder unit
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } mod_req_t;

  // request to the generator state
  typedef struct packed {
    logic             draw;
    logic [DataW-1:0] entropy;
  } draw_req_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_THR   = 6'b000010,
    ST_DRAW  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_MOD   = 6'b010000,
    ST_DONE  = 6'b100000
  } seq_st_t;

endpackage

[sv/lcg_bounded_random_unit.sv]
// top level: request sequencer, output register, generator and remainder unit
// depends on lbr_pkg, lbr_lcg_gen and lbr_mod_unit
//
// channel   dir  beat contents
// s_axis    in   tuser: kind; tdata: bound [31:0], entropy [63:32]
// m_axis    out  tdata: value [31:0]
// seed      in   seed_we / seed_wdata, loads the generator state
//
// raw request: a single draw; bound below two: zero result, no draw
// bounded request: the remainder unit runs twice (threshold, final reduction)
// with the draws between them, at most 64 draws per request
// one request at a time: s_axis_tready is high only while the sequencer idles
// the result waits in the output register; a new beat is taken meanwhile
// rst is synchronous and clears the generator state to zero
module lcg_bounded_random_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // bound [31:0], entropy [63:32]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // value [31:0]
);

  lbr_pkg::seq_st_t            st, st_next;
  logic                        kind_r;
  logic [lbr_pkg::DataW-1:0]   bound_r;
  logic [lbr_pkg::DataW-1:0]   entropy_r;
  logic [lbr_pkg::DataW-1:0]   thr;
  logic [lbr_pkg::DataW-1:0]   result;
  logic [lbr_pkg::CntW-1:0]    draws;
  logic [lbr_pkg::DataW-1:0]   lcg_state;
  logic [lbr_pkg::DataW-1:0]   rem;
  logic                        mod_busy;
  logic                        mod_done;
  logic                        in_beat;
  logic                        out_free;
  logic                        in_kind;
  logic [lbr_pkg::DataW-1:0]   in_bound;
  lbr_pkg::mod_req_t           mod_req;
  lbr_pkg::draw_req_t          draw_req;

  assign in_kind       = s_axis_tuser;
  assign in_bound      = s_axis_tdata[31:0];
  assign s_axis_tready = (st == lbr_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // generator
  assign draw_req.draw    = (st == lbr_pkg::ST_DRAW);
  assign draw_req.entropy = entropy_r;

  lbr_lcg_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .req        (draw_req),
    .lcg_state  (lcg_state)
  );

  // remainder requests: threshold at accept, final reduction after the draws
  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = lcg_state;
    mod_req.divisor  = bound_r;
    if (in_beat && in_kind && (in_bound >= lbr_pkg::MinBound)) begin
      mod_req.start    = 1'b1;
      mod_req.dividend = '0 - in_bound;
      mod_req.divisor  = in_bound;
    end else if (st == lbr_pkg::ST_CHECK && kind_r &&
                 !((lcg_state < thr) && (draws < lbr_pkg::DrawLimit))) begin
      mod_req.start = 1'b1;
    end
  end

  lbr_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .busy (mod_busy),
    .done (mod_done),
    .rem  (rem)
  );

  // sequencer
  always_comb begin
    st_next = st;
    unique case (st)
      lbr_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (!in_kind) begin
            st_next = lbr_pkg::ST_DRAW;
          end else if (in_bound < lbr_pkg::MinBound) begin
            st_next = lbr_pkg::ST_DONE;
          end else begin
            st_next = lbr_pkg::ST_THR;
          end
        end
      end
      lbr_pkg::ST_THR: begin
        if (mod_done) st_next = lbr_pkg::ST_DRAW;
      end
      lbr_pkg::ST_DRAW: st_next = lbr_pkg::ST_CHECK;
      lbr_pkg::ST_CHECK: begin
        if (!kind_r) begin
          st_next = lbr_pkg::ST_DONE;
        end else if ((lcg_state < thr) && (draws < lbr_pkg::DrawLimit)) begin
          st_next = lbr_pkg::ST_DRAW;
        end else begin
          st_next = lbr_pkg::ST_MOD;
        end
      end
      lbr_pkg::ST_MOD: begin
        if (mod_done) st_next = lbr_pkg::ST_DONE;
      end
      lbr_pkg::ST_DONE: begin
        if (out_free) st_next = lbr_pkg::ST_IDLE;
      end
      default: st_next = lbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= lbr_pkg::ST_IDLE;
      draws <= '0;
    end else begin
      st <= st_next;
      if (in_beat) begin
        draws <= '0;
      end else if (st == lbr_pkg::ST_DRAW) begin
        draws <= draws + 7'd1;
      end
    end
  end

  // request fields and intermediate results
  always_ff @(posedge clk) begin
    if (in_beat) begin
      kind_r    <= in_kind;
      bound_r   <= in_bound;
      entropy_r <= s_axis_tdata[63:32];
      result    <= '0;
    end
    if (st == lbr_pkg::ST_THR && mod_done) begin
      thr <= rem;
    end
    if (st == lbr_pkg::ST_CHECK && !kind_r) begin
      result <= lcg_state;
    end
    if (st == lbr_pkg::ST_MOD && mod_done) begin
      result <= rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (st == lbr_pkg::ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == lbr_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= result;
    end
  end

  // checks
  a_mod_not_restarted: assert property (@(posedge clk) disable iff (rst)
    mod_req.start |-> !mod_busy)
    else $error("remainder unit started while busy");

  a_bounded_in_range: assert property (@(posedge clk) disable iff (rst)
    (st == lbr_pkg::ST_DONE && kind_r && bound_r >= lbr_pkg::MinBound)
      |-> (result < bound_r))
    else $error("bounded result not below bound");

  a_draw_limit: assert property (@(posedge clk) disable iff (rst)
    draws <= lbr_pkg::DrawLimit)
    else $error("draw count beyond limit");

  a_small_bound_zero: assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_kind && in_bound < lbr_pkg::MinBound)
      |=> (st == lbr_pkg::ST_DONE && result == '0))
    else $error("small bound did not give zero");

endmodule

[sv/lbr_mod_unit.sv]
// shared remainder unit: restoring division, one quotient bit per cycle
// depends on lbr_pkg for widths and the request struct
module lbr_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  lbr_pkg::mod_req_t             req,
  output logic                          busy,
  output logic                          done,
  output logic [lbr_pkg::DataW-1:0]     rem
);

  logic [lbr_pkg::DataW-1:0] dvd;
  logic [lbr_pkg::DataW-1:0] dsr;
  logic [4:0]                cnt;
  logic [lbr_pkg::DataW:0]   trial;
  logic [lbr_pkg::DataW+1:0] diff;
  logic [lbr_pkg::DataW-1:0] rem_next;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem, dvd[lbr_pkg::DataW-1]};
    diff     = {1'b0, trial} - {2'b00, dsr};
    rem_next = diff[lbr_pkg::DataW+1] ? trial[lbr_pkg::DataW-1:0]
                                      : diff[lbr_pkg::DataW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[lbr_pkg::DataW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

[sv/lbr_lcg_gen.sv]
// generator state: seed load, zero reseed from entropy, one lcg step per draw
// depends on lbr_pkg for constants and the draw request struct
module lbr_lcg_gen (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seed_we,
  input  logic [lbr_pkg::DataW-1:0]     seed_wdata,
  input  lbr_pkg::draw_req_t            req,
  output logic [lbr_pkg::DataW-1:0]     lcg_state
);

  logic [lbr_pkg::DataW-1:0]    base;
  logic [lbr_pkg::DataW+20:0]   prod;
  logic [lbr_pkg::DataW-1:0]    lcg_state_next;

  // reseed on zero, then multiply-add mod 2^32
  always_comb begin
    base           = (lcg_state == '0) ? req.entropy : lcg_state;
    prod           = {21'd0, base} * {32'd0, lbr_pkg::LcgMul};
    lcg_state_next = prod[lbr_pkg::DataW-1:0] + lbr_pkg::LcgAdd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= '0;
    end else if (seed_we) begin
      lcg_state <= seed_wdata;
    end else if (req.draw) begin
      lcg_state <= lcg_state_next;
    end
  end

endmodule

[tb/lcg_bounded_random_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for lcg_bounded_random_unit: raw and bounded draws,
// seed loads, rejection loops and stalls on both streams against a local model
// depends on lbr_pkg (data width) and the block's rtl only

module lcg_bounded_random_unit_test;
  localparam int unsigned DataW = lbr_pkg::DataW;

  localparam logic [DataW-1:0] MULT          = 32'd1664525;
  localparam logic [DataW-1:0] INC           = 32'd1013904223;
  localparam logic [DataW-1:0] BOUND_MIN     = 32'd2;
  localparam int               DRAW_CAP      = 64;
  localparam logic             KIND_RAW      = 1'b0;
  localparam logic             KIND_BOUNDED  = 1'b1;
  localparam int               SETTLE_CYCLES = 8;
  localparam int               LONG_HOLD     = 300;
  localparam int               CYCLE_LIMIT   = 2_000_000;
  localparam int               PRINT_CAP     = 40;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        seed_we       = 1'b0;
  logic [31:0] seed_wdata    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // bound [31:0], entropy [63:32]
  logic        s_axis_tuser  = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // value [31:0]

  // model state and bookkeeping
  logic [DataW-1:0] gen_state     = '0;
  logic [DataW-1:0] stuck_entropy = '0;
  logic [DataW-1:0] pending_values[$];
  int error_count   = 0;
  int cycle_count   = 0;
  int raw_count     = 0;
  int bounded_count = 0;
  int seed_count    = 0;
  int reject_count  = 0;
  int checked_count = 0;
  bit sender_no_gap = 1'b0;
  bit sink_no_stall = 1'b0;
  int sink_hold     = 0;

  always #5 clk = ~clk;

  lcg_bounded_random_unit dut (
    .clk           (clk),
    .rst           (rst),
    .seed_we       (seed_we),
    .seed_wdata    (seed_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_values.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // entropy word whose successor is zero, so a zero state keeps coming back
  function automatic logic [DataW-1:0] zero_successor_seed();
    logic [DataW-1:0] inv;
    inv = MULT;
    repeat (5) inv = inv * (32'd2 - MULT * inv);
    return (32'd0 - INC) * inv;
  endfunction

  // one generator step, reseeding from entropy when the state is zero
  function automatic logic [DataW-1:0] step_generator(input logic [DataW-1:0] entropy);
    if (gen_state == '0)
      gen_state = entropy;
    gen_state = gen_state * MULT + INC;
    return gen_state;
  endfunction

  // value the block owes for one request
  function automatic logic [DataW-1:0] next_random_value(input logic kind,
      input logic [DataW-1:0] bound, input logic [DataW-1:0] entropy);
    logic [DataW-1:0] threshold;
    logic [DataW-1:0] r;
    int n;
    if (kind == KIND_RAW)
      return step_generator(entropy);
    if (bound < BOUND_MIN)
      return '0;
    threshold = (32'd0 - bound) % bound;
    r = step_generator(entropy);
    for (n = 1; n < DRAW_CAP && r < threshold; n++) begin
      r = step_generator(entropy);
      reject_count++;
    end
    return r % bound;
  endfunction

  // offer one request beat, keep it up until taken
  task automatic send_request(input logic kind, input logic [DataW-1:0] bound,
                              input logic [DataW-1:0] entropy);
    int gap;
    bit taken;
    gap = sender_no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {entropy, bound};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    pending_values.push_back(next_random_value(kind, bound, entropy));
    if (kind == KIND_RAW)
      raw_count++;
    else
      bounded_count++;
  endtask

  // stop offering and wait for every owed result, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(input logic [DataW-1:0] seed);
    drain_results();
    seed_we    <= 1'b1;
    seed_wdata <= seed;
    @(posedge clk);
    seed_we   <= 1'b0;
    gen_state  = seed;
    seed_count++;
  endtask

  task automatic check_value(input logic [DataW-1:0] got);
    logic [DataW-1:0] want;
    checked_count++;
    if (pending_values.size() == 0) begin
      report_mismatch($sformatf("value %h with no request outstanding", got));
      return;
    end
    want = pending_values.pop_front();
    if (got !== want)
      report_mismatch($sformatf("value %h, expected %h", got, want));
  endtask

  // result sink: random stalls, the occasional long hold-off, checks each beat
  initial begin : result_sink
    int stall;
    bit taken;
    @(posedge clk);
    forever begin
      stall = sink_no_stall ? 0 : $urandom_range(0, 4);
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk);
        taken = m_axis_tvalid;
        if (taken)
          check_value(m_axis_tdata);
        @(posedge clk);
      end while (!taken);
    end
  end

  // bounds weighted towards small, power-of-two and high-rejection values
  function automatic logic [DataW-1:0] pick_bound();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5)
      return $urandom_range(0, 1);
    if (sel < 30)
      return $urandom_range(2, 17);
    if (sel < 40)
      return 32'd1 << $urandom_range(1, 31);
    if (sel < 55)
      return 32'h8000_0000 | $urandom_range(1, 65535);
    if (sel < 60)
      return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [DataW-1:0] pick_entropy();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10)
      return '0;
    if (sel < 20)
      return stuck_entropy;
    return $urandom;
  endfunction

  function automatic logic [DataW-1:0] pick_seed();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return stuck_entropy;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_requests(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 35)
        send_request(KIND_RAW, $urandom, pick_entropy());
      else
        send_request(KIND_BOUNDED, pick_bound(), pick_entropy());
      // now and then the sender waits for the block to empty
      if ($urandom_range(0, 99) == 0)
        drain_results();
    end
  endtask

  // state is zero out of reset, so the first draw reseeds
  task automatic test_raw_after_reset();
    send_request(KIND_RAW, $urandom, 32'd0);
    send_request(KIND_RAW, 32'hFFFF_FFFF, $urandom);
    send_request(KIND_RAW, 32'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_seed_extremes();
    load_seed(32'd0);
    send_request(KIND_RAW, $urandom, 32'hFFFF_FFFF);
    load_seed(32'hFFFF_FFFF);
    send_request(KIND_RAW, $urandom, $urandom);
    load_seed(32'h8000_0000);
    send_request(KIND_BOUNDED, 32'hFFFF_FFFF, $urandom);
  endtask

  // bounds below two leave a zero state alone, then edge bounds
  task automatic test_small_and_edge_bounds();
    load_seed(32'd0);
    send_request(KIND_BOUNDED, 32'd0, $urandom);
    send_request(KIND_BOUNDED, 32'd1, 32'hFFFF_FFFF);
    send_request(KIND_RAW, 32'd1, $urandom);
    send_request(KIND_BOUNDED, 32'd2, $urandom);
    send_request(KIND_BOUNDED, 32'd3, $urandom);
    send_request(KIND_BOUNDED, 32'h8000_0000, $urandom);
    send_request(KIND_BOUNDED, 32'h8000_0001, $urandom);
    send_request(KIND_BOUNDED, 32'hFFFF_FFFF, $urandom);
    send_request(KIND_BOUNDED, 32'hFFFF_FFFE, $urandom);
  endtask

  // generator falling back to zero: endless rejection and reseed mid-loop
  task automatic test_stuck_generator();
    load_seed(32'd0);
    send_request(KIND_RAW, $urandom, stuck_entropy);
    send_request(KIND_BOUNDED, 32'd3, stuck_entropy);
    load_seed(stuck_entropy);
    send_request(KIND_BOUNDED, 32'd3, $urandom);
  endtask

  task automatic test_random_mix();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 0)
        load_seed('0);
      else if (phase == 1)
        load_seed(32'hFFFF_FFFF);
      else
        load_seed(pick_seed());
      // one phase runs with no idling on either side
      sender_no_gap = (phase == 5);
      sink_no_stall = (phase == 5);
      run_random_requests(155);
    end
    sender_no_gap = 1'b0;
    sink_no_stall = 1'b0;
  endtask

  // sink holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    load_seed($urandom);
    sender_no_gap = 1'b1;
    sink_hold     = LONG_HOLD;
    run_random_requests(60);
    sender_no_gap = 1'b0;
    drain_results();
  endtask

  initial begin : test_sequence
    stuck_entropy = zero_successor_seed();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_raw_after_reset();
    test_seed_extremes();
    test_small_and_edge_bounds();
    test_stuck_generator();
    test_random_mix();
    test_output_backpressure();
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d raw and %0d bounded requests across %0d seed loads",
             raw_count, bounded_count, seed_count);
    $display("%0d results compared, %0d rejected draws in the model",
             checked_count, reject_count);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
